@@ hw/rtl/fixed_point_matrix_multiply_accumulate_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the fixed-point matrix multiply-accumulate unit
// Property checks are active in simulation and empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_MATRIX_MULTIPLY_ACCUMULATE_UNIT_DEFINES_SVH
`define FIXED_POINT_MATRIX_MULTIPLY_ACCUMULATE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Checks that a condition holds whenever its antecedent holds in the same cycle.
`define FPMMA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that a condition holds in the cycle after its antecedent.
`define FPMMA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define FPMMA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define FPMMA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

@@ hw/rtl/fpmma_pkg.sv @@
// ----------------------------------------------------------------------------
// fpmma_pkg
// Shared constants, codes and command types of the matrix multiply-accumulate
// unit.
// ----------------------------------------------------------------------------
package fpmma_pkg;

   // Matrix geometry and number format
   localparam int MAX_DIM   = 8;
   localparam int FRAC_BITS = 8;
   localparam int DATA_W    = 32;
   localparam int DEPTH     = MAX_DIM * MAX_DIM;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int IDX_W     = $clog2(MAX_DIM);
   localparam int DIM_W     = $clog2(MAX_DIM + 1);

   // Fixed field widths of the stream and register interfaces
   localparam int FIELD_IDX_W = 3;
   localparam int OP_W        = 2;
   localparam int REG_W       = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 4;
   localparam int TDATA_W     = 40;
   localparam int TDATA_PAD_W = TDATA_W - DATA_W - 2 * FIELD_IDX_W;

   // Field positions inside the request and response tdata words
   localparam int REQ_ROW_LSB = 0;
   localparam int REQ_COL_LSB = FIELD_IDX_W;
   localparam int REQ_VAL_LSB = 2 * FIELD_IDX_W;
   localparam int RSP_ROW_LSB = DATA_W;
   localparam int RSP_COL_LSB = DATA_W + FIELD_IDX_W;

   // Request operation codes
   typedef enum logic [OP_W-1:0] {
      OP_LOAD_A  = 2'd0,
      OP_LOAD_B  = 2'd1,
      OP_LOAD_C  = 2'd2,
      OP_COMPUTE = 2'd3
   } op_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      REG_ROWS_M  = 2'd0,
      REG_COLS_N  = 2'd1,
      REG_INNER_K = 2'd2
   } reg_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic             ld_en;
      logic             c_rd;
      logic             mac_rd;
      logic             acc_init;
      logic             wr_back;
      logic             last;
      logic [IDX_W-1:0] row_idx;
      logic [IDX_W-1:0] col_idx;
      logic [IDX_W-1:0] inner_idx;
   } dp_cmd_type;

   // Column-major store address of an element
   function automatic logic [ADDR_W-1:0] addr_of(input logic [FIELD_IDX_W-1:0] row,
                                                input logic [FIELD_IDX_W-1:0] col);
      return ADDR_W'(int'(col) * MAX_DIM + int'(row));
   endfunction

endpackage

@@ hw/rtl/fixed_point_matrix_multiply_accumulate_unit.sv @@
// ----------------------------------------------------------------------------
// fixed_point_matrix_multiply_accumulate_unit
// Computes C = A*B + C in signed 32-bit fixed point on matrices of up to
// eight by eight elements, loaded one element per transfer.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Purpose
//   req_*    in         element loads of A, B, C and compute commands
//   rsp_*    out        updated C entries, column-major, tlast on the final one
//   csr_*    in/out     dimension registers rows_m, cols_n, inner_k
//
// Loads may follow each other in every cycle while no compute runs.
// A compute walks the C entries in turn; each needs one C read, k reads of the
// A and B stores through the multiplier, two drain states and one write-back.
// Requests are not taken while a compute runs.
// Reset is synchronous and clears the C store's written flags at once.
// A stalled result holds the output register and delays the next write-back.
// ----------------------------------------------------------------------------
`include "fixed_point_matrix_multiply_accumulate_unit_defines.svh"

module fixed_point_matrix_multiply_accumulate_unit
   import fpmma_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [2:0] row_index, [5:3] col_index, [37:6] element_value, [39:38] zero
   input  logic [TDATA_W-1:0]    req_tdata,
   // [1:0] operation
   input  logic [OP_W-1:0]       req_tuser,
   // Result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [31:0] result_value, [34:32] result_row, [37:35] result_col, [39:38] zero
   output logic [TDATA_W-1:0]    rsp_tdata,
   output logic                  rsp_tlast,
   // Configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [REG_W-1:0]          rows_m_ff, cols_n_ff, inner_k_ff;
   logic [DIM_W-1:0]          rows_dim, cols_dim, inner_dim;
   logic                      csr_wr;
   reg_type                   csr_reg;
   op_type                    req_op;
   dp_cmd_type                dp_cmd;
   logic                      out_free;
   logic signed [DATA_W-1:0]  rsp_value;
   logic [FIELD_IDX_W-1:0]    rsp_row, rsp_col;

   // A zero dimension acts as one, a large one as the store size
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [REG_W-1:0] d);
      if (d == '0) begin
         return DIM_W'(1);
      end else if (int'(d) > MAX_DIM) begin
         return DIM_W'(MAX_DIM);
      end else begin
         return DIM_W'(d);
      end
   endfunction

   // Register write decode
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_reg    = reg_type'(csr_paddr[3:2]);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_m_ff  <= REG_W'(8);
         cols_n_ff  <= REG_W'(8);
         inner_k_ff <= REG_W'(8);
      end else if (csr_wr) begin
         case (csr_reg)
            REG_ROWS_M:  rows_m_ff  <= csr_pwdata[REG_W-1:0];
            REG_COLS_N:  cols_n_ff  <= csr_pwdata[REG_W-1:0];
            REG_INNER_K: inner_k_ff <= csr_pwdata[REG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Register read-back
   always_comb begin
      case (csr_reg)
         REG_ROWS_M:  csr_prdata = CSR_DATA_W'(rows_m_ff);
         REG_COLS_N:  csr_prdata = CSR_DATA_W'(cols_n_ff);
         REG_INNER_K: csr_prdata = CSR_DATA_W'(inner_k_ff);
         default:     csr_prdata = '0;
      endcase
   end

   assign rows_dim  = clamp_dim(rows_m_ff);
   assign cols_dim  = clamp_dim(cols_n_ff);
   assign inner_dim = clamp_dim(inner_k_ff);

   assign req_op = op_type'(req_tuser);

   // Controller
   fpmma_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_op),
      .rows_dim   (rows_dim),
      .cols_dim   (cols_dim),
      .inner_dim  (inner_dim),
      .out_free   (out_free),
      .dp_cmd     (dp_cmd)
   );

   // Datapath
   fpmma_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .dp_cmd     (dp_cmd),
      .req_op     (req_op),
      .req_row    (req_tdata[REQ_ROW_LSB +: FIELD_IDX_W]),
      .req_col    (req_tdata[REQ_COL_LSB +: FIELD_IDX_W]),
      .req_value  (req_tdata[REQ_VAL_LSB +: DATA_W]),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_value  (rsp_value),
      .rsp_row    (rsp_row),
      .rsp_col    (rsp_col),
      .rsp_last   (rsp_tlast)
   );

   // Result packing
   assign rsp_tdata = {{TDATA_PAD_W{1'b0}}, rsp_col, rsp_row, rsp_value};

   // A compute transfer closes the request side on the next cycle
   `FPMMA_ASSERT_NEXT(a_compute_blocks, clock, reset,
      req_tvalid && req_tready && req_op == OP_COMPUTE, !req_tready,
      "request accepted during a compute run")

   // A write-back never overwrites a result still waiting to be taken
   `FPMMA_ASSERT_SAME(a_wrback_free, clock, reset,
      dp_cmd.wr_back, !rsp_tvalid || rsp_tready,
      "write-back overwrote a pending result")

   // Result coordinates stay inside the configured matrix
   `FPMMA_ASSERT_SAME(a_rsp_in_range, clock, reset,
      rsp_tvalid, int'(rsp_row) < int'(rows_dim) && int'(rsp_col) < int'(cols_dim),
      "result coordinate outside the matrix")

   // The last flag marks the bottom-right entry
   `FPMMA_ASSERT_SAME(a_last_corner, clock, reset,
      rsp_tvalid && rsp_tlast,
      int'(rsp_row) + 1 == int'(rows_dim) && int'(rsp_col) + 1 == int'(cols_dim),
      "last flag on a wrong entry")

endmodule

@@ hw/rtl/fpmma_ctrl.sv @@
// ----------------------------------------------------------------------------
// fpmma_ctrl
// Controller that accepts request items and sequences the multiply-accumulate
// walk over the result entries and the inner dimension.
// ----------------------------------------------------------------------------
module fpmma_ctrl
   import fpmma_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  op_type           req_op,
   input  logic [DIM_W-1:0] rows_dim,
   input  logic [DIM_W-1:0] cols_dim,
   input  logic [DIM_W-1:0] inner_dim,
   input  logic             out_free,
   output dp_cmd_type       dp_cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD_C,
      ST_MAC,
      ST_DRAIN1,
      ST_DRAIN2,
      ST_WRITE
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] row_ff, row_in;
   logic [IDX_W-1:0] col_ff, col_in;
   logic [IDX_W-1:0] inner_ff, inner_in;
   logic             row_last, col_last, inner_last;

   // End-of-range flags for the three loop counters
   assign row_last   = (DIM_W'(row_ff) + DIM_W'(1)) == rows_dim;
   assign col_last   = (DIM_W'(col_ff) + DIM_W'(1)) == cols_dim;
   assign inner_last = (DIM_W'(inner_ff) + DIM_W'(1)) == inner_dim;

   // Next-state logic: column outer, row inner, inner dimension innermost
   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      inner_in = inner_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_op == OP_COMPUTE) begin
               row_in   = '0;
               col_in   = '0;
               state_in = ST_LOAD_C;
            end
         end
         ST_LOAD_C: begin
            inner_in = '0;
            state_in = ST_MAC;
         end
         ST_MAC: begin
            inner_in = inner_ff + IDX_W'(1);
            if (inner_last) begin
               state_in = ST_DRAIN1;
            end
         end
         ST_DRAIN1: begin
            state_in = ST_DRAIN2;
         end
         ST_DRAIN2: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (out_free) begin
               if (row_last) begin
                  row_in = '0;
                  if (col_last) begin
                     state_in = ST_IDLE;
                  end else begin
                     col_in   = col_ff + IDX_W'(1);
                     state_in = ST_LOAD_C;
                  end
               end else begin
                  row_in   = row_ff + IDX_W'(1);
                  state_in = ST_LOAD_C;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff   <= '0;
         col_ff   <= '0;
         inner_ff <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         inner_ff <= inner_in;
      end
   end

   // Requests are taken only between compute runs
   assign req_tready = (state_ff == ST_IDLE);

   // Datapath commands
   always_comb begin
      dp_cmd.ld_en     = req_tvalid && req_tready && (req_op != OP_COMPUTE);
      dp_cmd.c_rd      = (state_ff == ST_LOAD_C);
      dp_cmd.mac_rd    = (state_ff == ST_MAC);
      dp_cmd.acc_init  = (state_ff == ST_MAC) && (inner_ff == '0);
      dp_cmd.wr_back   = (state_ff == ST_WRITE) && out_free;
      dp_cmd.last      = row_last && col_last;
      dp_cmd.row_idx   = row_ff;
      dp_cmd.col_idx   = col_ff;
      dp_cmd.inner_idx = inner_ff;
   end

endmodule

@@ hw/rtl/fpmma_dp.sv @@
// ----------------------------------------------------------------------------
// fpmma_dp
// Datapath with the A, B and C element stores, the registered fixed-point
// multiplier, the accumulator and the result output register.
// ----------------------------------------------------------------------------
module fpmma_dp
   import fpmma_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  dp_cmd_type              dp_cmd,
   input  op_type                  req_op,
   input  logic [FIELD_IDX_W-1:0]  req_row,
   input  logic [FIELD_IDX_W-1:0]  req_col,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                    out_free,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic signed [DATA_W-1:0] rsp_value,
   output logic [FIELD_IDX_W-1:0]  rsp_row,
   output logic [FIELD_IDX_W-1:0]  rsp_col,
   output logic                    rsp_last
);

   logic [DATA_W-1:0]          a_mem [DEPTH];
   logic [DATA_W-1:0]          b_mem [DEPTH];
   logic [DATA_W-1:0]          c_mem [DEPTH];
   logic [DEPTH-1:0]           c_vld_ff;

   logic                       ld_in_range;
   logic [ADDR_W-1:0]          ld_addr;
   logic                       a_we, b_we, c_ld_we, c_we;
   logic [ADDR_W-1:0]          a_rd_addr, b_rd_addr, c_addr, c_wr_addr;
   logic [DATA_W-1:0]          c_wr_data;
   logic [FIELD_IDX_W-1:0]     row_f, col_f, inner_f;

   logic signed [DATA_W-1:0]   a_q_ff, b_q_ff, c_q_ff;
   logic                       c_q_vld_ff;
   logic                       rd_vld_ff, mul_vld_ff;
   logic signed [2*DATA_W-1:0] prod_ff;
   logic [DATA_W-1:0]          acc_ff;
   logic                       rsp_vld_ff;
   logic [DATA_W-1:0]          rsp_value_ff;
   logic [FIELD_IDX_W-1:0]     rsp_row_ff, rsp_col_ff;
   logic                       rsp_last_ff;

   // Load decode; out-of-range indexes are dropped
   assign ld_in_range = (int'(req_row) < MAX_DIM) && (int'(req_col) < MAX_DIM);
   assign ld_addr     = addr_of(req_row, req_col);
   assign a_we        = dp_cmd.ld_en && ld_in_range && (req_op == OP_LOAD_A);
   assign b_we        = dp_cmd.ld_en && ld_in_range && (req_op == OP_LOAD_B);
   assign c_ld_we     = dp_cmd.ld_en && ld_in_range && (req_op == OP_LOAD_C);

   // Walk addresses: A(i,p), B(p,j) and C(i,j)
   assign row_f     = FIELD_IDX_W'(dp_cmd.row_idx);
   assign col_f     = FIELD_IDX_W'(dp_cmd.col_idx);
   assign inner_f   = FIELD_IDX_W'(dp_cmd.inner_idx);
   assign a_rd_addr = addr_of(row_f, inner_f);
   assign b_rd_addr = addr_of(inner_f, col_f);
   assign c_addr    = addr_of(row_f, col_f);

   // The C store is written by loads and by the write-back of a finished entry
   assign c_we      = c_ld_we || dp_cmd.wr_back;
   assign c_wr_addr = dp_cmd.wr_back ? c_addr : ld_addr;
   assign c_wr_data = dp_cmd.wr_back ? acc_ff : req_value;

   // A store with a registered read port
   always_ff @(posedge clock) begin
      if (a_we) begin
         a_mem[ld_addr] <= req_value;
      end
      if (dp_cmd.mac_rd) begin
         a_q_ff <= a_mem[a_rd_addr];
      end
   end

   // B store with a registered read port
   always_ff @(posedge clock) begin
      if (b_we) begin
         b_mem[ld_addr] <= req_value;
      end
      if (dp_cmd.mac_rd) begin
         b_q_ff <= b_mem[b_rd_addr];
      end
   end

   // C store with a registered read port
   always_ff @(posedge clock) begin
      if (c_we) begin
         c_mem[c_wr_addr] <= c_wr_data;
      end
      if (dp_cmd.c_rd) begin
         c_q_ff     <= c_mem[c_addr];
         c_q_vld_ff <= c_vld_ff[c_addr];
      end
   end

   // Written flags of the C store; an unwritten entry reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= '0;
      end else if (c_we) begin
         c_vld_ff[c_wr_addr] <= 1'b1;
      end
   end

   // Pipeline valid flags for the read and multiply stages
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff  <= 1'b0;
         mul_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff  <= dp_cmd.mac_rd;
         mul_vld_ff <= rd_vld_ff;
      end
   end

   // Full 64-bit signed product
   always_ff @(posedge clock) begin
      if (rd_vld_ff) begin
         prod_ff <= a_q_ff * b_q_ff;
      end
   end

   // Accumulator: seeded with the old C entry, then adds the scaled products.
   // The arithmetic shift keeps the low word, so the sum wraps at 32 bits.
   always_ff @(posedge clock) begin
      if (dp_cmd.acc_init) begin
         acc_ff <= c_q_vld_ff ? c_q_ff : '0;
      end else if (mul_vld_ff) begin
         acc_ff <= acc_ff + prod_ff[FRAC_BITS +: DATA_W];
      end
   end

   // Result output register
   assign out_free = !rsp_vld_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (dp_cmd.wr_back) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.wr_back) begin
         rsp_value_ff <= acc_ff;
         rsp_row_ff   <= row_f;
         rsp_col_ff   <= col_f;
         rsp_last_ff  <= dp_cmd.last;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_row    = rsp_row_ff;
   assign rsp_col    = rsp_col_ff;
   assign rsp_last   = rsp_last_ff;

endmodule
